// ===== sv/ihs_pkg.sv =====
// Shared types and constants for the index heap sort core.
package ihs_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_W           = 32;
  localparam int IDX_OUT_W       = 6;
  localparam int JOB_CNT_W       = IDX_OUT_W + 1;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;

  // Word index of the sort direction register.
  localparam logic REG_SORT_DESC = 1'b0;

  typedef struct packed {
    logic signed [KEY_W-1:0] record_key;
    logic                    last_record;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]    sorted_index;
    logic signed [KEY_W-1:0] sorted_key;
    logic                    overflowed;
    logic                    last_result;
  } out_item_t;

  // One loaded set, handed from the loader to the sort engine.
  typedef struct packed {
    logic                 bank;
    logic [JOB_CNT_W-1:0] count;
    logic                 ovf;
  } job_t;

endpackage

// ===== sv/ihs_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module ihs_ram
  #(parameter int W = 8,
    parameter int D = 16)
  (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr0,
  output logic [W-1:0]         rdata0,
  input  logic [$clog2(D)-1:0] raddr1,
  output logic [W-1:0]         rdata1
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== sv/ihs_front.sv =====
// Loader: accepts key items, writes them to the key store and closes sets.
module ihs_front
  import ihs_pkg::*;
  #(parameter int MAX_RECORDS = MAX_RECORDS_DEF)
  (
  input  logic                        clk,
  input  logic                        rst_n,
  input  in_item_t                    in_item,
  input  logic                        push,
  output logic                        full,
  output logic                        kw_en,
  output logic [$clog2(MAX_RECORDS):0] kw_addr,
  output logic [KEY_W-1:0]            kw_data,
  output logic                        job_push,
  output job_t                        job,
  input  logic                        job_full
);

  localparam int IDXW = $clog2(MAX_RECORDS);
  localparam int CNTW = $clog2(MAX_RECORDS + 1);

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic            bank_r, bank_nxt;
  logic            acc, room;
  logic [CNTW-1:0] n_new;

  assign full = job_full;
  assign acc  = push & ~job_full;
  assign room = cnt_r < CNTW'(MAX_RECORDS);

  assign kw_en   = acc & room;
  assign kw_addr = {bank_r, cnt_r[IDXW-1:0]};
  assign kw_data = in_item.record_key;

  assign n_new     = room ? cnt_r + CNTW'(1) : cnt_r;
  assign job_push  = acc & in_item.last_record;
  assign job.bank  = bank_r;
  assign job.count = JOB_CNT_W'(n_new);
  assign job.ovf   = ovf_r | ~room;

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (acc) begin
      if (in_item.last_record) begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = ~bank_r;
      end else if (room) begin
        cnt_nxt = n_new;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ===== sv/ihs_jobq.sv =====
// Two-entry queue of loaded sets between the loader and the sort engine.
module ihs_jobq
  import ihs_pkg::*;
  (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t       ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign valid   = cnt_r != 2'd0;
  assign head    = ent_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_job;
    end
  end

endmodule

// ===== sv/ihs_back.sv =====
// Sort engine: heap build, sift-down sort over the index heap, result emission.
module ihs_back
  import ihs_pkg::*;
  #(parameter int MAX_RECORDS = MAX_RECORDS_DEF)
  (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         sort_desc,
  input  logic                         job_valid,
  input  job_t                         job,
  output logic                         job_pop,
  output logic [$clog2(MAX_RECORDS):0] kra0,
  output logic [$clog2(MAX_RECORDS):0] kra1,
  input  logic [KEY_W-1:0]             krd0,
  input  logic [KEY_W-1:0]             krd1,
  output out_item_t                    out_item,
  output logic                         empty,
  input  logic                         pop
);

  localparam int IDXW = $clog2(MAX_RECORDS);
  localparam int CNTW = $clog2(MAX_RECORDS + 1);
  localparam int HD   = 2 ** IDXW;

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_INIT = 15'b000000000000010,
    ST_LD   = 15'b000000000000100,
    ST_LDH  = 15'b000000000001000,
    ST_HK   = 15'b000000000010000,
    ST_CHK  = 15'b000000000100000,
    ST_RDH  = 15'b000000001000000,
    ST_RDK  = 15'b000000010000000,
    ST_CMP  = 15'b000000100000000,
    ST_SW0  = 15'b000001000000000,
    ST_SW1  = 15'b000010000000000,
    ST_EA   = 15'b000100000000000,
    ST_EB   = 15'b001000000000000,
    ST_EC   = 15'b010000000000000,
    ST_ED   = 15'b100000000000000
  } state_t;

  state_t              st_r, st_nxt;
  logic                build_r, build_nxt;
  logic [IDXW-1:0]     i_r, i_nxt, bot_r, bot_nxt, pos_r, pos_nxt, k_r, k_nxt;
  logic [CNTW-1:0]     n_r, n_nxt, n_m1;
  logic                bank_r, bank_nxt, ovf_r, ovf_nxt;
  logic                outv_r, outv_nxt;

  // Datapath registers, no reset needed.
  logic [IDXW-1:0]     held_r, held_nxt, hl_r, hl_nxt, hr_r, hr_nxt;
  logic [IDXW-1:0]     pick_r, pick_nxt, pval_r, pval_nxt, idx_r, idx_nxt;
  logic [IDXW:0]       lc_r, lc_nxt;
  logic                rcok_r, rcok_nxt;
  logic signed [KEY_W-1:0] hkey_r, hkey_nxt, pkey_r, pkey_nxt, key_r, key_nxt;
  out_item_t           out_r, out_nxt;

  logic                hwe;
  logic [IDXW-1:0]     hwa, hwd, hra0, hra1, hrd0, hrd1;
  logic [IDXW:0]       lc, rc;
  logic                load_out, kl_gt_kr, kr_above, pk_above;
  logic signed [KEY_W-1:0] skl, skr;

  ihs_ram #(.W(IDXW), .D(HD)) u_heap (
    .clk    (clk),
    .we     (hwe),
    .waddr  (hwa),
    .wdata  (hwd),
    .raddr0 (hra0),
    .rdata0 (hrd0),
    .raddr1 (hra1),
    .rdata1 (hrd1)
  );

  assign n_m1 = n_r - CNTW'(1);
  assign lc   = {pos_r, 1'b1};
  assign rc   = {pos_r, 1'b0} + (IDXW+1)'(2);
  assign skl  = krd0;
  assign skr  = krd1;

  // "Above" means the first key belongs nearer the heap root.
  assign kl_gt_kr = skl > skr;
  assign kr_above = sort_desc ? kl_gt_kr : (skr > skl);
  assign pk_above = sort_desc ? (pkey_r < hkey_r) : (pkey_r > hkey_r);

  assign load_out = (st_r == ST_ED) & (~outv_r | pop);
  assign empty    = ~outv_r;
  assign out_item = out_r;

  always_comb begin
    st_nxt    = st_r;
    build_nxt = build_r;
    i_nxt     = i_r;
    bot_nxt   = bot_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    bank_nxt  = bank_r;
    ovf_nxt   = ovf_r;
    held_nxt  = held_r;
    hl_nxt    = hl_r;
    hr_nxt    = hr_r;
    pick_nxt  = pick_r;
    pval_nxt  = pval_r;
    idx_nxt   = idx_r;
    lc_nxt    = lc_r;
    rcok_nxt  = rcok_r;
    hkey_nxt  = hkey_r;
    pkey_nxt  = pkey_r;
    key_nxt   = key_r;
    out_nxt   = out_r;
    outv_nxt  = outv_r & ~pop;
    job_pop   = 1'b0;
    hwe       = 1'b0;
    hwa       = pos_r;
    hwd       = held_r;
    hra0      = i_r;
    hra1      = i_r;
    kra0      = {bank_r, hrd0};
    kra1      = {bank_r, hrd1};

    unique case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          n_nxt    = job.count[CNTW-1:0];
          bank_nxt = job.bank;
          ovf_nxt  = job.ovf;
          i_nxt    = '0;
          st_nxt   = ST_INIT;
        end
      end
      ST_INIT: begin
        hwe = 1'b1;
        hwa = i_r;
        hwd = i_r;
        if (i_r == n_m1[IDXW-1:0]) begin
          build_nxt = 1'b1;
          i_nxt     = n_m1[IDXW-1:0] >> 1;
          bot_nxt   = n_m1[IDXW-1:0];
          st_nxt    = ST_LD;
        end else begin
          i_nxt = i_r + IDXW'(1);
        end
      end
      ST_LD: begin
        hra0   = i_r;
        st_nxt = ST_LDH;
      end
      ST_LDH: begin
        held_nxt = hrd0;
        kra0     = {bank_r, hrd0};
        pos_nxt  = i_r;
        st_nxt   = ST_HK;
      end
      ST_HK: begin
        hkey_nxt = krd0;
        st_nxt   = ST_CHK;
      end
      ST_CHK: begin
        if (lc <= {1'b0, bot_r}) begin
          lc_nxt   = lc;
          rcok_nxt = rc <= {1'b0, bot_r};
          hra0     = lc[IDXW-1:0];
          hra1     = (rc <= {1'b0, bot_r}) ? rc[IDXW-1:0] : lc[IDXW-1:0];
          st_nxt   = ST_RDH;
        end else begin
          // The held index settles here and this sift-down is over.
          hwe = 1'b1;
          if (build_r && i_r != '0) begin
            i_nxt  = i_r - IDXW'(1);
            st_nxt = ST_LD;
          end else begin
            build_nxt = 1'b0;
            if (bot_r == '0) begin
              k_nxt  = '0;
              st_nxt = ST_EA;
            end else begin
              i_nxt  = bot_r;
              st_nxt = ST_SW0;
            end
          end
        end
      end
      ST_RDH: begin
        hl_nxt = hrd0;
        hr_nxt = hrd1;
        kra0   = {bank_r, hrd0};
        kra1   = {bank_r, hrd1};
        st_nxt = ST_RDK;
      end
      ST_RDK: begin
        if (rcok_r && kr_above) begin
          pick_nxt = lc_r[IDXW-1:0] + IDXW'(1);
          pval_nxt = hr_r;
          pkey_nxt = krd1;
        end else begin
          pick_nxt = lc_r[IDXW-1:0];
          pval_nxt = hl_r;
          pkey_nxt = krd0;
        end
        st_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (pk_above) begin
          hwe     = 1'b1;
          hwd     = pval_r;
          pos_nxt = pick_r;
          st_nxt  = ST_CHK;
        end else begin
          // The held index settles at the current slot and this sift-down is over.
          pos_nxt = pos_r;
          lc_nxt  = lc_r;
          st_nxt  = ST_CHK;
          bot_nxt = bot_r;
          hwe     = 1'b1;
          if (build_r && i_r != '0) begin
            i_nxt  = i_r - IDXW'(1);
            st_nxt = ST_LD;
          end else begin
            build_nxt = 1'b0;
            if (bot_r == '0) begin
              k_nxt  = '0;
              st_nxt = ST_EA;
            end else begin
              i_nxt  = bot_r;
              st_nxt = ST_SW0;
            end
          end
        end
      end
      ST_SW0: begin
        hra0   = '0;
        hra1   = i_r;
        st_nxt = ST_SW1;
      end
      ST_SW1: begin
        // The old root moves to the sorted tail; the tail entry sifts from the root.
        hwe      = 1'b1;
        hwa      = i_r;
        hwd      = hrd0;
        held_nxt = hrd1;
        kra0     = {bank_r, hrd1};
        pos_nxt  = '0;
        bot_nxt  = i_r - IDXW'(1);
        st_nxt   = ST_HK;
      end
      ST_EA: begin
        hra0   = k_r;
        st_nxt = ST_EB;
      end
      ST_EB: begin
        idx_nxt = hrd0;
        kra0    = {bank_r, hrd0};
        st_nxt  = ST_EC;
      end
      ST_EC: begin
        key_nxt = krd0;
        st_nxt  = ST_ED;
      end
      ST_ED: begin
        if (load_out) begin
          outv_nxt             = 1'b1;
          out_nxt.sorted_index = IDX_OUT_W'(idx_r);
          out_nxt.sorted_key   = key_r;
          out_nxt.overflowed   = ovf_r;
          out_nxt.last_result  = k_r == n_m1[IDXW-1:0];
          if (k_r == n_m1[IDXW-1:0]) begin
            job_pop = 1'b1;
            st_nxt  = ST_IDLE;
          end else begin
            k_nxt  = k_r + IDXW'(1);
            st_nxt = ST_EA;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      build_r <= 1'b0;
      i_r     <= '0;
      bot_r   <= '0;
      pos_r   <= '0;
      k_r     <= '0;
      n_r     <= '0;
      bank_r  <= 1'b0;
      ovf_r   <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      build_r <= build_nxt;
      i_r     <= i_nxt;
      bot_r   <= bot_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
      bank_r  <= bank_nxt;
      ovf_r   <= ovf_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    hl_r   <= hl_nxt;
    hr_r   <= hr_nxt;
    pick_r <= pick_nxt;
    pval_r <= pval_nxt;
    idx_r  <= idx_nxt;
    lc_r   <= lc_nxt;
    rcok_r <= rcok_nxt;
    hkey_r <= hkey_nxt;
    pkey_r <= pkey_nxt;
    key_r  <= key_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== sv/index_heap_sort_core.sv =====
// Top level of the index heap sort core: loader, set queue, key store, sort engine.
//
//   channel   direction  handshake          payload
//   input     in         push / full        in_item  (record_key, last_record)
//   result    out        pop / empty        out_item (sorted_index, sorted_key, ...)
//   config    in/out     psel/penable/...   sort_descending at byte address 0
//
// Loading accepts one item per cycle while full is low. The sort engine then
// works through each set with a read-compare-write loop over the index heap
// and key store ports. The key store is double banked, so the next set loads
// while one is sorted; full rises once a second closed set waits behind the
// one being sorted. There is no clearing pass after reset. A stalled result
// holds the engine at its emit step.
module index_heap_sort_core
  import ihs_pkg::*;
  #(parameter int MAX_RECORDS = MAX_RECORDS_DEF)
  (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  push,
  output logic                  full,
  output out_item_t             out_item,
  output logic                  empty,
  input  logic                  pop,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int KAW = $clog2(MAX_RECORDS) + 1;

  logic           sort_desc_r, sort_desc_nxt;
  logic           kw_en;
  logic [KAW-1:0] kw_addr, kra0, kra1;
  logic [KEY_W-1:0] kw_data, krd0, krd1;
  logic           job_push, job_full, job_pop, job_valid;
  job_t           job_in, job_head;
  logic           reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == REG_SORT_DESC;
  assign prdata  = reg_hit ? CFG_DATA_W'(sort_desc_r) : '0;

  always_comb begin
    sort_desc_nxt = sort_desc_r;
    if (psel && penable && pwrite && reg_hit) begin
      sort_desc_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_desc_r <= 1'b0;
    end else begin
      sort_desc_r <= sort_desc_nxt;
    end
  end

  ihs_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .kw_en    (kw_en),
    .kw_addr  (kw_addr),
    .kw_data  (kw_data),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full)
  );

  ihs_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .valid    (job_valid),
    .head     (job_head)
  );

  ihs_ram #(.W(KEY_W), .D(2 ** KAW)) u_keys (
    .clk    (clk),
    .we     (kw_en),
    .waddr  (kw_addr),
    .wdata  (kw_data),
    .raddr0 (kra0),
    .rdata0 (krd0),
    .raddr1 (kra1),
    .rdata1 (krd1)
  );

  ihs_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sort_desc (sort_desc_r),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .kra0      (kra0),
    .kra1      (kra1),
    .krd0      (krd0),
    .krd1      (krd1),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
